FILE: hw/rtl/ekf_pkg.sv
`default_nettype none

package ekf_pkg;

  // Text store and window sizes
  localparam int BUFFER_BYTES = 1024;
  localparam int WINDOW_BYTES = 13;
  localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
  localparam int WIN_BITS     = WINDOW_BYTES * 8;

  // Result field widths
  localparam int POS_W = 10;
  localparam int IDX_W = 5;
  localparam int KLEN_W = 4;
  localparam int REM_W = 11;

  // Keyword table
  localparam int KW_COUNT = 17;

  // Each keyword packed with its final character in the low byte, so byte i
  // lines up with window entry i (entry 0 is the newest byte).
  localparam logic [WIN_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    WIN_BITS'("eversionR"),     WIN_BITS'("eversionL"),
    WIN_BITS'("dorsiflexionU"), WIN_BITS'("dorsiflexionD"),
    WIN_BITS'("extensionU"),    WIN_BITS'("extensionD"),
    WIN_BITS'("motor1H"),       WIN_BITS'("motor1AH"),
    WIN_BITS'("motor2H"),       WIN_BITS'("motor2AH"),
    WIN_BITS'("motor3H"),       WIN_BITS'("motor3AH"),
    WIN_BITS'("goHome1"),       WIN_BITS'("goHome2"),
    WIN_BITS'("goHome3"),       WIN_BITS'("goHome"),
    WIN_BITS'("setHome")
  };

  localparam logic [KLEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd9, 4'd9, 4'd13, 4'd13, 4'd10, 4'd10, 4'd7, 4'd8, 4'd7,
    4'd8, 4'd7, 4'd8, 4'd7, 4'd7, 4'd7, 4'd6, 4'd7
  };

  // Keywords that end on the same byte start earliest when longest; this
  // order is longest first, lower index first among equal lengths.
  localparam logic [IDX_W-1:0] KW_ORDER [KW_COUNT] = '{
    5'd2, 5'd3, 5'd4, 5'd5, 5'd0, 5'd1, 5'd7, 5'd9, 5'd11,
    5'd6, 5'd8, 5'd10, 5'd12, 5'd13, 5'd14, 5'd16, 5'd15
  };

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic [7:0]       text;
    logic             take;
    logic             last;
    logic [LEN_W-1:0] length;
  } ekf_entry_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } ekf_qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ekf_front.sv
`default_nettype none

module ekf_front import ekf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_byte,
  input  wire ekf_qstat_t qstat,
  output logic            push,
  output ekf_entry_t      push_entry
);

  logic             ended;
  logic [LEN_W-1:0] count;
  logic             open_text;
  logic             take;

  // Classify the byte: counted text, terminator or ignored
  assign open_text = !ended && (count < LEN_W'(BUFFER_BYTES));
  assign take      = open_text && (text_byte != 8'd0);

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  assign push_entry.text   = text_byte;
  assign push_entry.take   = take;
  assign push_entry.last   = last_byte;
  assign push_entry.length = take ? count + LEN_W'(1) : count;

  // Track text end and length; clear after the last byte of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ended <= 1'b0;
      count <= '0;
    end else if (push) begin
      if (last_byte) begin
        ended <= 1'b0;
        count <= '0;
      end else if (take) begin
        count <= count + LEN_W'(1);
      end else if (open_text) begin
        ended <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ekf_queue.sv
`default_nettype none

module ekf_queue import ekf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire ekf_entry_t push_entry,
  output ekf_qstat_t      qstat,
  input  wire logic       pop,
  output logic            head_valid,
  output ekf_entry_t      head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ekf_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign qstat.full = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (!push && pop) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ekf_back.sv
`default_nettype none

module ekf_back import ekf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire ekf_entry_t        head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   found,
  output logic [IDX_W-1:0]       keyword_index,
  output logic [POS_W-1:0]       start_position,
  output logic [KLEN_W-1:0]      keyword_length,
  output logic [REM_W-1:0]       remaining_length
);

  logic [WIN_BITS-1:0] window;
  logic                best_found;
  logic [LEN_W-1:0]    best_start;
  logic [IDX_W-1:0]    best_kw;
  logic [LEN_W-1:0]    best_end;

  logic [WIN_BITS-1:0] win_next;
  logic [KW_COUNT-1:0] hit;
  logic                pick_valid;
  logic [IDX_W-1:0]    pick;
  logic [LEN_W-1:0]    pick_start;
  logic                better;
  logic                best_found_next;
  logic [LEN_W-1:0]    best_start_next;
  logic [IDX_W-1:0]    best_kw_next;
  logic [LEN_W-1:0]    best_end_next;
  logic                out_free;

  // Shift the new byte into the window and compare every keyword
  always_comb begin
    win_next = {window[WIN_BITS-9:0], head.text};
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = head.take && (head.length >= LEN_W'(KW_LEN[k]));
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        if (i < int'(KW_LEN[k]) && win_next[i*8 +: 8] != KW_TEXT[k][i*8 +: 8]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // Pick the earliest-starting hit of this byte
  always_comb begin
    pick_valid = 1'b0;
    pick       = '0;
    for (int n = KW_COUNT - 1; n >= 0; n--) begin
      if (hit[KW_ORDER[n]]) begin
        pick_valid = 1'b1;
        pick       = KW_ORDER[n];
      end
    end
    pick_start = head.length - LEN_W'(KW_LEN[pick]);
  end

  // Keep the earliest match, lower index on equal start
  always_comb begin
    better = pick_valid && (!best_found || pick_start < best_start ||
             (pick_start == best_start && pick < best_kw));
    best_found_next = best_found || better;
    best_start_next = better ? pick_start  : best_start;
    best_kw_next    = better ? pick        : best_kw;
    best_end_next   = better ? head.length : best_end;
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = head_valid && (!head.last || out_free);

  // Advance the search state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      best_found <= 1'b0;
      best_start <= '1;
      best_kw    <= '0;
      best_end   <= '0;
    end else if (pop) begin
      if (head.last) begin
        window     <= '0;
        best_found <= 1'b0;
        best_start <= '1;
        best_kw    <= '0;
        best_end   <= '0;
      end else if (head.take) begin
        window     <= win_next;
        best_found <= best_found_next;
        best_start <= best_start_next;
        best_kw    <= best_kw_next;
        best_end   <= best_end_next;
      end
    end
  end

  // Hold the result until the downstream side takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      found            <= best_found_next;
      keyword_index    <= best_found_next ? best_kw_next : '0;
      start_position   <= best_found_next ? best_start_next[POS_W-1:0] : '0;
      keyword_length   <= best_found_next ? KW_LEN[best_kw_next] : '0;
      remaining_length <= best_found_next ?
                          REM_W'(head.length - best_end_next) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/earliest_keyword_finder.sv
`default_nettype none

// Earliest keyword finder. Command text arrives one byte per transfer on the
// input channel, with last_byte marking the final byte of a buffer; a zero
// byte ends the text and bytes after it, or beyond 1024 text bytes, are
// ignored. After the last byte one result transfer reports whether any of the
// 17 command keywords occurred, which one starts earliest (lower table index
// on equal start), where it starts, its length and how many text bytes follow
// it. One byte is taken every clock cycle while the queue is not full; the
// whole keyword compare and best match update of a byte is combinational in
// the back end. The front end and the back end are parted by a four-entry
// queue, so input transfers go on while a result waits on a stalled output.
// The last byte goes through the queue; its pop registers the result.
module earliest_keyword_finder import ekf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        text_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   found,
  output logic [IDX_W-1:0]       keyword_index,
  output logic [POS_W-1:0]       start_position,
  output logic [KLEN_W-1:0]      keyword_length,
  output logic [REM_W-1:0]       remaining_length
);

  ekf_qstat_t qstat;
  logic       push;
  ekf_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  ekf_entry_t head;

  ekf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .last_byte  (last_byte),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  ekf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ekf_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .keyword_index    (keyword_index),
    .start_position   (start_position),
    .keyword_length   (keyword_length),
    .remaining_length (remaining_length)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ekf_checker.sv
`default_nettype none

module ekf_checker import ekf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              found,
  input wire logic [IDX_W-1:0]  keyword_index,
  input wire logic [POS_W-1:0]  start_position,
  input wire logic [KLEN_W-1:0] keyword_length,
  input wire logic [REM_W-1:0]  remaining_length
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(found) && $stable(keyword_index) &&
      $stable(start_position) && $stable(keyword_length) &&
      $stable(remaining_length))
    else $error("result payload changed while stalled");

  // No match reports all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> keyword_index == '0 && start_position == '0 &&
      keyword_length == '0 && remaining_length == '0)
    else $error("empty result carries non-zero fields");

  // A match names a table keyword of a legal length
  a_match_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> keyword_index < IDX_W'(KW_COUNT) &&
      keyword_length == KW_LEN[keyword_index])
    else $error("match reports a bad keyword or length");

  // Nothing is offered straight after a reset edge
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind earliest_keyword_finder ekf_checker u_ekf_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .found            (found),
  .keyword_index    (keyword_index),
  .start_position   (start_position),
  .keyword_length   (keyword_length),
  .remaining_length (remaining_length)
);

`default_nettype wire
